// ===== sv/scts_pkg.sv =====
// Shared types and constants of the shared-clock slave task scheduler.
package scts_pkg;

  localparam int unsigned MaxTasksDef  = 8;
  localparam int unsigned DelayBitsDef = 16;

  localparam logic [7:0] StartByte0 = 8'h00;
  localparam logic [7:0] SlaveIdRst = 8'h01;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_RSVD  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_RESP
  } seq_state_e;

  typedef struct packed {
    logic        ack_send;
    logic [7:0]  ack_byte0;
    logic [7:0]  ack_byte1;
    logic        running;
    logic        tick_matched;
    logic [31:0] tick_data;
    logic [7:0]  run_pending;
  } rsp_t;

endpackage

// ===== sv/scts_if.sv =====
// Request and response channel interfaces of the slave task scheduler.
interface scts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  frame_byte0;
  logic [7:0]  frame_byte1;
  logic [7:0]  frame_byte2;
  logic [7:0]  frame_byte3;
  logic [7:0]  frame_byte4;
  logic [7:0]  ack_payload;
  logic [2:0]  task_index;
  logic [15:0] task_delay;
  logic [15:0] task_period;
  logic        task_present;

  modport source (
    output valid, req_type, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
           frame_byte4, ack_payload, task_index, task_delay, task_period, task_present,
    input  ready
  );
  modport sink (
    input  valid, req_type, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
           frame_byte4, ack_payload, task_index, task_delay, task_period, task_present,
    output ready
  );
endinterface

interface scts_rsp_if;
  logic        valid;
  logic        ready;
  logic        ack_send;
  logic [7:0]  ack_byte0;
  logic [7:0]  ack_byte1;
  logic        running;
  logic        tick_matched;
  logic [31:0] tick_data;
  logic [7:0]  run_pending;

  modport source (
    output valid, ack_send, ack_byte0, ack_byte1, running, tick_matched, tick_data,
           run_pending,
    input  ready
  );
  modport sink (
    input  valid, ack_send, ack_byte0, ack_byte1, running, tick_matched, tick_data,
           run_pending,
    output ready
  );
endinterface

// ===== sv/scts_slot_mem.sv =====
// Task slot table: synchronous memory of delay and period with per-slot valid bits.
module scts_slot_mem #(
  parameter int unsigned MAX_TASKS  = 8,
  parameter int unsigned DELAY_BITS = 16,
  parameter int unsigned IDX_W      = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [IDX_W-1:0]      wr_addr_i,
  input  logic                  wr_present_i,
  input  logic [DELAY_BITS-1:0] wr_delay_i,
  input  logic [DELAY_BITS-1:0] wr_period_i,
  input  logic                  rd_en_i,
  input  logic [IDX_W-1:0]      rd_addr_i,
  output logic                  rd_present_o,
  output logic [DELAY_BITS-1:0] rd_delay_o,
  output logic [DELAY_BITS-1:0] rd_period_o
);
  import scts_pkg::*;

  logic [2*DELAY_BITS-1:0] mem [MAX_TASKS];
  logic [MAX_TASKS-1:0]    vld_q;
  logic [2*DELAY_BITS-1:0] rd_data_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_period_i, wr_delay_i};
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= wr_present_i;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // An unwritten slot reads as empty with zero delay and period.
  assign rd_present_o = rd_vld_q;
  assign rd_delay_o   = rd_vld_q ? rd_data_q[DELAY_BITS-1:0] : '0;
  assign rd_period_o  = rd_vld_q ? rd_data_q[2*DELAY_BITS-1:DELAY_BITS] : '0;

endmodule

// ===== sv/scts_seq.sv =====
// Request sequencer: frame decode, slot walk with read-modify-write, run flags.
module scts_seq #(
  parameter int unsigned MAX_TASKS  = 8,
  parameter int unsigned DELAY_BITS = 16,
  parameter int unsigned IDX_W      = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            node_id_i,
  scts_req_if.sink              req,
  output scts_pkg::rsp_t        res_o,
  output logic                  res_valid_o,
  input  logic                  res_free_i,
  output logic                  mem_wr_en_o,
  output logic [IDX_W-1:0]      mem_wr_addr_o,
  output logic                  mem_wr_present_o,
  output logic [DELAY_BITS-1:0] mem_wr_delay_o,
  output logic [DELAY_BITS-1:0] mem_wr_period_o,
  output logic                  mem_rd_en_o,
  output logic [IDX_W-1:0]      mem_rd_addr_o,
  input  logic                  mem_rd_present_i,
  input  logic [DELAY_BITS-1:0] mem_rd_delay_i,
  input  logic [DELAY_BITS-1:0] mem_rd_period_i
);
  import scts_pkg::*;

  seq_state_e           state_q, state_d;
  logic                 started_q;
  logic [31:0]          capt_q;
  logic [MAX_TASKS-1:0] run_q;
  logic [IDX_W-1:0]     walk_q;
  logic                 wb_pend_q;
  logic [IDX_W-1:0]     wb_idx_q;
  logic                 ack_q, matched_q;
  logic [7:0]           a0_q, a1_q;

  logic                 accept, walk_last, idx_ok, start_hit, tick_hit;
  logic                 start_go, tick_go, flag_clr;
  logic [6:0]           idx_ext;
  logic [IDX_W-1:0]     idx;
  logic [31:0]          delay_ext, period_ext;
  logic                 wb_due;
  logic [DELAY_BITS-1:0] wb_delay;
  logic [7:0]           pend;

  assign accept    = req.valid && req.ready;
  assign walk_last = (walk_q == IDX_W'(MAX_TASKS - 1));
  assign idx_ext   = {4'b0, req.task_index};
  assign idx       = idx_ext[IDX_W-1:0];
  assign idx_ok    = (idx_ext < 7'(MAX_TASKS));
  assign start_hit = (req.frame_byte0 == StartByte0) && (req.frame_byte1 == node_id_i);
  assign tick_hit  = (req.frame_byte0 == node_id_i);
  assign delay_ext  = {16'b0, req.task_delay};
  assign period_ext = {16'b0, req.task_period};

  assign start_go = accept && (req_type_e'(req.req_type) == REQ_TICK) && !started_q
                    && start_hit;
  assign tick_go  = accept && (req_type_e'(req.req_type) == REQ_TICK) && started_q
                    && tick_hit;
  assign flag_clr = accept && idx_ok && ((req_type_e'(req.req_type) == REQ_WRITE)
                    || (req_type_e'(req.req_type) == REQ_CLEAR));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req.valid) begin
          state_d = (req_type_e'(req.req_type) == REQ_TICK && started_q) ? ST_WALK : ST_RESP;
        end
      end
      ST_WALK: begin
        if (walk_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_RESP;
      ST_RESP: begin
        if (res_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    req.ready   = 1'b0;
    mem_rd_en_o = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE:  req.ready   = 1'b1;
      ST_WALK:  mem_rd_en_o = 1'b1;
      ST_DRAIN: ;
      ST_RESP:  res_valid_o = 1'b1;
      default:  ;
    endcase
  end

  assign mem_rd_addr_o = walk_q;

  // Write-back of the slot read in the previous cycle; the walk never reads the
  // slot it is writing, and task writes only happen while idle.
  assign wb_due   = wb_pend_q && mem_rd_present_i && (mem_rd_delay_i == '0);
  assign wb_delay = (mem_rd_delay_i == '0) ? mem_rd_period_i
                                           : mem_rd_delay_i - DELAY_BITS'(1);

  always_comb begin
    mem_wr_en_o      = 1'b0;
    mem_wr_addr_o    = wb_idx_q;
    mem_wr_present_o = 1'b1;
    mem_wr_delay_o   = wb_delay;
    mem_wr_period_o  = mem_rd_period_i;
    if (accept && req_type_e'(req.req_type) == REQ_WRITE && idx_ok) begin
      mem_wr_en_o      = 1'b1;
      mem_wr_addr_o    = idx;
      mem_wr_present_o = req.task_present;
      mem_wr_delay_o   = req.task_present ? delay_ext[DELAY_BITS-1:0] : '0;
      mem_wr_period_o  = req.task_present ? period_ext[DELAY_BITS-1:0] : '0;
    end else if (wb_pend_q && mem_rd_present_i) begin
      mem_wr_en_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      started_q <= 1'b0;
      capt_q    <= '0;
      run_q     <= '0;
      walk_q    <= '0;
      wb_pend_q <= 1'b0;
      wb_idx_q  <= '0;
      ack_q     <= 1'b0;
      matched_q <= 1'b0;
      a0_q      <= '0;
      a1_q      <= '0;
    end else begin
      state_q   <= state_d;
      wb_pend_q <= mem_rd_en_o;
      wb_idx_q  <= walk_q;
      if (accept) begin
        walk_q <= '0;
      end else if (mem_rd_en_o) begin
        walk_q <= walk_q + IDX_W'(1);
      end
      // Start frame, addressed tick, or a silent acknowledge for anything else.
      if (start_go) begin
        started_q <= 1'b1;
        ack_q     <= 1'b1;
        matched_q <= 1'b0;
        a0_q      <= StartByte0;
        a1_q      <= node_id_i;
      end else if (tick_go) begin
        capt_q    <= {req.frame_byte4, req.frame_byte3, req.frame_byte2,
                      req.frame_byte1};
        matched_q <= 1'b1;
        ack_q     <= 1'b1;
        a0_q      <= node_id_i;
        a1_q      <= req.ack_payload;
      end else if (accept) begin
        ack_q     <= 1'b0;
        matched_q <= 1'b0;
        a0_q      <= '0;
        a1_q      <= '0;
      end
      if (flag_clr) begin
        run_q[idx] <= 1'b0;
      end else if (wb_due) begin
        run_q[wb_idx_q] <= 1'b1;
      end
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_pend
    if (g < MAX_TASKS) begin : g_slot
      assign pend[g] = run_q[g];
    end else begin : g_none
      assign pend[g] = 1'b0;
    end
  end

  always_comb begin
    res_o.ack_send     = ack_q;
    res_o.ack_byte0    = a0_q;
    res_o.ack_byte1    = a1_q;
    res_o.running      = started_q;
    res_o.tick_matched = matched_q;
    res_o.tick_data    = capt_q;
    res_o.run_pending  = pend;
  end

endmodule

// ===== sv/shared_clock_slave_task_scheduler_core.sv =====
// Top level of the shared-clock slave task scheduler.
// Sequencing: a task write, run-flag clear or non-running frame goes from idle straight to
// the result state; a running tick walks every slot, then passes a drain state to the result.
// Throughput: one request at a time, set by the slot walk over the single table read port.
// A result register lets the next request in while a result waits to be taken.
// Reset: asynchronous, clears control, run flags and slot valid bits; no clearing pass.
module shared_clock_slave_task_scheduler_core #(
  parameter int unsigned MAX_TASKS  = scts_pkg::MaxTasksDef,
  parameter int unsigned DELAY_BITS = scts_pkg::DelayBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  scts_req_if.sink    req_i,
  scts_rsp_if.source  rsp_o
);
  import scts_pkg::*;

  localparam int unsigned IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  // Slave identifier register; the user must write it only while idle, the block does not enforce it.
  logic [7:0] node_id_q;

  // Sequencer to result register
  rsp_t res;
  logic res_valid, res_free;

  // Slot table port signals
  logic                  wr_en, wr_present, rd_en, rd_present;
  logic [IdxW-1:0]       wr_addr, rd_addr;
  logic [DELAY_BITS-1:0] wr_delay, wr_period, rd_delay, rd_period;

  // Result register: hold a finished result until the sink takes it.
  logic rsp_vld_q;
  rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= SlaveIdRst;
    end else if (cfg_we_i) begin
      node_id_q <= cfg_wdata_i;
    end
  end

  scts_seq #(
    .MAX_TASKS  (MAX_TASKS),
    .DELAY_BITS (DELAY_BITS),
    .IDX_W      (IdxW)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .node_id_i        (node_id_q),
    .req              (req_i),
    .res_o            (res),
    .res_valid_o      (res_valid),
    .res_free_i       (res_free),
    .mem_wr_en_o      (wr_en),
    .mem_wr_addr_o    (wr_addr),
    .mem_wr_present_o (wr_present),
    .mem_wr_delay_o   (wr_delay),
    .mem_wr_period_o  (wr_period),
    .mem_rd_en_o      (rd_en),
    .mem_rd_addr_o    (rd_addr),
    .mem_rd_present_i (rd_present),
    .mem_rd_delay_i   (rd_delay),
    .mem_rd_period_i  (rd_period)
  );

  scts_slot_mem #(
    .MAX_TASKS  (MAX_TASKS),
    .DELAY_BITS (DELAY_BITS),
    .IDX_W      (IdxW)
  ) u_slot_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (wr_en),
    .wr_addr_i    (wr_addr),
    .wr_present_i (wr_present),
    .wr_delay_i   (wr_delay),
    .wr_period_i  (wr_period),
    .rd_en_i      (rd_en),
    .rd_addr_i    (rd_addr),
    .rd_present_o (rd_present),
    .rd_delay_o   (rd_delay),
    .rd_period_o  (rd_period)
  );

  // The register is free when empty or being drained in this cycle.
  assign res_free = !rsp_vld_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (res_valid && res_free) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_free) begin
      rsp_q <= res;
    end
  end

  assign rsp_o.valid        = rsp_vld_q;
  assign rsp_o.ack_send     = rsp_q.ack_send;
  assign rsp_o.ack_byte0    = rsp_q.ack_byte0;
  assign rsp_o.ack_byte1    = rsp_q.ack_byte1;
  assign rsp_o.running      = rsp_q.running;
  assign rsp_o.tick_matched = rsp_q.tick_matched;
  assign rsp_o.tick_data    = rsp_q.tick_data;
  assign rsp_o.run_pending  = rsp_q.run_pending;

endmodule

// ===== sv/scts_chk.sv =====
// Port-level assertion checker for the slave task scheduler, bound to the top level.
module scts_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        ack_send,
  input logic [7:0]  ack_byte0,
  input logic [7:0]  ack_byte1,
  input logic        running,
  input logic        tick_matched,
  input logic [31:0] tick_data,
  input logic [7:0]  run_pending
);
  logic seen_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_run_q <= 1'b0;
    end else if (rsp_valid && rsp_ready && running) begin
      seen_run_q <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(ack_send) && $stable(ack_byte0)
      && $stable(ack_byte1) && $stable(tick_data) && $stable(run_pending))
    else $error("response changed while stalled");

  a_no_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !ack_send |-> ack_byte0 == 8'h00 && ack_byte1 == 8'h00)
    else $error("acknowledge bytes set without acknowledge");

  a_match_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && tick_matched |-> ack_send && running)
    else $error("matched tick without acknowledge or while stopped");

  a_start_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && ack_send && !tick_matched |-> ack_byte0 == 8'h00 && running)
    else $error("start acknowledge malformed");

  a_stay_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && seen_run_q |-> running)
    else $error("running dropped after start");

endmodule

bind shared_clock_slave_task_scheduler_core scts_chk u_scts_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid    (rsp_o.valid),
  .rsp_ready    (rsp_o.ready),
  .ack_send     (rsp_o.ack_send),
  .ack_byte0    (rsp_o.ack_byte0),
  .ack_byte1    (rsp_o.ack_byte1),
  .running      (rsp_o.running),
  .tick_matched (rsp_o.tick_matched),
  .tick_data    (rsp_o.tick_data),
  .run_pending  (rsp_o.run_pending)
);
